[src/vmmu_pkg.sv]
// ----------------------------------------------------------------------------
// vmmu_pkg
// Shared types and constants for the move unit with addressing modes.
// ----------------------------------------------------------------------------
package vmmu_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam int REG_COUNT     = 256;
	localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
	localparam logic [63:0] ADDR48_MASK = 64'h0000FFFFFFFFFFFF;

	// destination modes
	localparam logic [1:0] DST_REG    = 2'd0;
	localparam logic [1:0] DST_ABS    = 2'd1;
	localparam logic [1:0] DST_OFF    = 2'd2;
	localparam logic [1:0] DST_SCALED = 2'd3;

	// source modes
	localparam logic [2:0] SRC_IMM    = 3'd0;
	localparam logic [2:0] SRC_REG    = 3'd1;
	localparam logic [2:0] SRC_ABS    = 3'd2;
	localparam logic [2:0] SRC_OFF    = 3'd3;
	localparam logic [2:0] SRC_SCALED = 3'd4;

	// Decoded instruction passed from front to back
	typedef struct packed {
		logic [1:0]  dmode;
		logic [2:0]  smode;
		logic [3:0]  nbytes;
		logic [7:0]  dst_reg;
		logic [7:0]  dst_index_reg;
		logic [5:0]  dst_shift;
		logic [47:0] dst_disp;
		logic [7:0]  src_reg;
		logic [7:0]  src_index_reg;
		logic [5:0]  src_shift;
		logic [63:0] src_disp;
	} instr_t;

	function automatic logic [63:0] width_mask(input logic [3:0] nb);
		logic [63:0] m;
		case (nb)
			4'd1:    m = 64'h00000000000000FF;
			4'd2:    m = 64'h000000000000FFFF;
			4'd4:    m = 64'h00000000FFFFFFFF;
			4'd6:    m = 64'h0000FFFFFFFFFFFF;
			default: m = 64'hFFFFFFFFFFFFFFFF;
		endcase
		return m;
	endfunction

endpackage

[src/vmmu_front.sv]
// ----------------------------------------------------------------------------
// vmmu_front
// Accepts items, drops unknown opcodes, decodes modes and width, and
// queues decoded instructions for the back end (two-entry queue).
// ----------------------------------------------------------------------------
module vmmu_front import vmmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  opcode,
	input  logic [2:0]  width_code,
	input  logic [7:0]  dst_reg,
	input  logic [7:0]  dst_index_reg,
	input  logic [5:0]  dst_shift,
	input  logic [47:0] dst_disp,
	input  logic [7:0]  src_reg,
	input  logic [7:0]  src_index_reg,
	input  logic [5:0]  src_shift,
	input  logic [63:0] src_disp,
	output logic        q_valid,
	input  logic        q_pop,
	output instr_t      q_data
);

	instr_t     fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	instr_t     dec;
	logic       push, legal;

	assign in_ready = (count_q != 2'd2);
	assign legal    = (opcode < 5'd20);
	assign push     = in_valid && in_ready && legal;
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = fifo_q[rd_ptr_q];

	// decode; opcode is dst mode * 5 + src mode, split by range compares
	always_comb begin
		dec = '0;
		if (opcode >= 5'd15) begin
			dec.dmode = DST_SCALED;
			dec.smode = 3'(opcode - 5'd15);
		end else if (opcode >= 5'd10) begin
			dec.dmode = DST_OFF;
			dec.smode = 3'(opcode - 5'd10);
		end else if (opcode >= 5'd5) begin
			dec.dmode = DST_ABS;
			dec.smode = 3'(opcode - 5'd5);
		end else begin
			dec.dmode = DST_REG;
			dec.smode = 3'(opcode);
		end
		case (width_code)
			3'd0:    dec.nbytes = 4'd1;
			3'd1:    dec.nbytes = 4'd2;
			3'd2:    dec.nbytes = 4'd4;
			3'd3:    dec.nbytes = 4'd6;
			default: dec.nbytes = 4'd8;
		endcase
		dec.dst_reg       = dst_reg;
		dec.dst_index_reg = dst_index_reg;
		dec.dst_shift     = dst_shift;
		dec.dst_disp      = dst_disp;
		dec.src_reg       = src_reg;
		dec.src_index_reg = src_index_reg;
		dec.src_shift     = src_shift;
		dec.src_disp      = src_disp;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= dec;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0) else $error("queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count invalid");

endmodule

[src/vmmu_back.sv]
// ----------------------------------------------------------------------------
// vmmu_back
// Executes one queued move: four register-file reads with registered data,
// address sums, byte-serial memory read of a memory source, then a register write
// or a byte-serial memory write, and an output register.
// Memory is one byte array with one read and one write port; each byte
// address wraps on its own.
// ----------------------------------------------------------------------------
module vmmu_back import vmmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  instr_t      q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] moved_value,
	output logic [47:0] target_address,
	output logic        to_register
);

	typedef enum logic [2:0] {
		S_IDLE, S_REG, S_ADDR, S_MRD, S_WR, S_OUT
	} state_t;

	state_t     state_q;
	instr_t     ins_q;
	logic [2:0] rcnt_q;
	logic [3:0] bcnt_q;
	logic [2:0] bprev;

	// register file; valid bits make unwritten registers read as zero
	logic [63:0]             rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0]    rfv_q;
	logic [REG_IDX_BITS-1:0] ra, rf_waddr;
	logic [63:0]             rd_q, rdata, rf_wdata;
	logic                    rdv_q, rf_we;

	// byte memory
	logic [7:0]               byte_mem [1 << MEM_ADDR_BITS];
	logic [MEM_ADDR_BITS-1:0] mem_raddr, mem_waddr;
	logic [7:0]               mem_rd_q;
	logic                     mem_we;

	logic [63:0]              sreg_q, sidx_q, dreg_q, didx_q, val_q, m;
	logic [MEM_ADDR_BITS-1:0] saddr_q, daddr_q, saddr, daddr, sidx_sh, didx_sh;

	assign m     = width_mask(ins_q.nbytes);
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign rdata = rdv_q ? rd_q : 64'd0;
	assign bprev = 3'(bcnt_q - 4'd1);

	// register read order: src base, src index, dst base, dst index
	always_comb begin
		case (rcnt_q)
			3'd0:    ra = REG_IDX_BITS'(ins_q.src_reg);
			3'd1:    ra = REG_IDX_BITS'(ins_q.src_index_reg);
			3'd2:    ra = REG_IDX_BITS'(ins_q.dst_reg);
			default: ra = REG_IDX_BITS'(ins_q.dst_index_reg);
		endcase
	end

	// register file ports
	assign rf_we    = (state_q == S_WR) && (ins_q.dmode == DST_REG);
	assign rf_waddr = REG_IDX_BITS'(ins_q.dst_reg);
	assign rf_wdata = (dreg_q & ~m) | val_q;

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
		rd_q <= rf_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rfv_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (rf_we) rfv_q[rf_waddr] <= 1'b1;
			rdv_q <= rfv_q[ra];
		end
	end

	// address sums; only the low memory bits of the sum matter
	assign sidx_sh = sidx_q[MEM_ADDR_BITS-1:0] << ins_q.src_shift;
	assign didx_sh = didx_q[MEM_ADDR_BITS-1:0] << ins_q.dst_shift;

	always_comb begin
		case (ins_q.smode)
			SRC_OFF:    saddr = sreg_q[MEM_ADDR_BITS-1:0]
				+ ins_q.src_disp[MEM_ADDR_BITS-1:0];
			SRC_SCALED: saddr = sreg_q[MEM_ADDR_BITS-1:0] + sidx_sh
				+ ins_q.src_disp[MEM_ADDR_BITS-1:0];
			default:    saddr = ins_q.src_disp[MEM_ADDR_BITS-1:0];
		endcase
		case (ins_q.dmode)
			DST_OFF:    daddr = dreg_q[MEM_ADDR_BITS-1:0]
				+ ins_q.dst_disp[MEM_ADDR_BITS-1:0];
			DST_SCALED: daddr = dreg_q[MEM_ADDR_BITS-1:0] + didx_sh
				+ ins_q.dst_disp[MEM_ADDR_BITS-1:0];
			default:    daddr = ins_q.dst_disp[MEM_ADDR_BITS-1:0];
		endcase
	end

	// byte memory ports: one byte per cycle, read data registered
	assign mem_raddr = saddr_q + MEM_ADDR_BITS'(bcnt_q);
	assign mem_waddr = daddr_q + MEM_ADDR_BITS'(bcnt_q);
	assign mem_we    = (state_q == S_WR) && (ins_q.dmode != DST_REG);

	always_ff @(posedge clk) begin
		if (mem_we) byte_mem[mem_waddr] <= val_q[8*bcnt_q[2:0] +: 8];
		mem_rd_q <= byte_mem[mem_raddr];
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ins_q          <= '0;
			rcnt_q         <= 3'd0;
			bcnt_q         <= 4'd0;
			sreg_q         <= '0;
			sidx_q         <= '0;
			dreg_q         <= '0;
			didx_q         <= '0;
			saddr_q        <= '0;
			daddr_q        <= '0;
			val_q          <= '0;
			out_valid      <= 1'b0;
			moved_value    <= '0;
			target_address <= '0;
			to_register    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (q_valid) begin
					ins_q   <= q_data;
					rcnt_q  <= 3'd0;
					state_q <= S_REG;
				end
				// a read is issued each cycle; its data arrives the cycle after
				S_REG: begin
					if (rcnt_q == 3'd1) sreg_q <= rdata;
					if (rcnt_q == 3'd2) sidx_q <= rdata;
					if (rcnt_q == 3'd3) dreg_q <= rdata;
					if (rcnt_q == 3'd4) didx_q <= rdata;
					rcnt_q <= rcnt_q + 3'd1;
					if (rcnt_q == 3'd4) state_q <= S_ADDR;
				end
				S_ADDR: begin
					saddr_q <= saddr;
					daddr_q <= daddr;
					bcnt_q  <= 4'd0;
					case (ins_q.smode)
						SRC_IMM: begin
							val_q   <= ins_q.src_disp & m;
							state_q <= S_WR;
						end
						SRC_REG: begin
							val_q   <= sreg_q & m;
							state_q <= S_WR;
						end
						default: begin
							val_q   <= '0;
							state_q <= S_MRD;
						end
					endcase
				end
				// whole source is read before any destination byte is written
				S_MRD: begin
					if (bcnt_q != 4'd0) val_q[8*bprev +: 8] <= mem_rd_q;
					if (bcnt_q == ins_q.nbytes) begin
						bcnt_q  <= 4'd0;
						state_q <= S_WR;
					end else begin
						bcnt_q <= bcnt_q + 4'd1;
					end
				end
				S_WR: begin
					if (ins_q.dmode == DST_REG) begin
						moved_value    <= val_q;
						target_address <= 48'(rf_waddr);
						to_register    <= 1'b1;
						out_valid      <= 1'b1;
						state_q        <= S_OUT;
					end else if (bcnt_q == ins_q.nbytes - 4'd1) begin
						moved_value    <= val_q;
						target_address <= 48'(daddr_q);
						to_register    <= 1'b0;
						out_valid      <= 1'b1;
						bcnt_q         <= 4'd0;
						state_q        <= S_OUT;
					end else begin
						bcnt_q <= bcnt_q + 4'd1;
					end
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result outside output state");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == S_REG) else $error("pop did not start work");
	a_reg_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && to_register |-> target_address[47:REG_IDX_BITS] == '0)
		else $error("register number out of range");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(moved_value)
		&& $stable(target_address) && $stable(to_register))
		else $error("result changed while waiting");
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= 4'd8) else $error("byte counter out of range");

endmodule

[src/vm_move_unit_addressing_modes.sv]
// ----------------------------------------------------------------------------
// vm_move_unit_addressing_modes
// Move unit: decoding front end, two-entry queue, sequenced back end.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | opcode .. src_disp
//  out     | out_valid / out_ready  | moved_value, target_address, to_register
//
// The back end handles one item at a time and pops the next only after the result
// is taken. An immediate or register source into a register goes through pop, the
// register reads, address, write and output; a memory source adds a byte-serial
// read before the write, and a memory destination is written byte by byte.
// Reset clears the register file valid bits; memory is not cleared.
// While out_ready is low the queue takes two more items, then in_ready drops.
// Opcodes 20 to 31 are accepted and give no result.
// ----------------------------------------------------------------------------
module vm_move_unit_addressing_modes import vmmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  opcode,
	input  logic [2:0]  width_code,
	input  logic [7:0]  dst_reg,
	input  logic [7:0]  dst_index_reg,
	input  logic [5:0]  dst_shift,
	input  logic [47:0] dst_disp,
	input  logic [7:0]  src_reg,
	input  logic [7:0]  src_index_reg,
	input  logic [5:0]  src_shift,
	input  logic [63:0] src_disp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] moved_value,
	output logic [47:0] target_address,
	output logic        to_register
);

	logic   q_valid, q_pop;
	instr_t q_data;

	vmmu_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .width_code, .dst_reg,
		.dst_index_reg, .dst_shift, .dst_disp, .src_reg, .src_index_reg,
		.src_shift, .src_disp, .q_valid, .q_pop, .q_data
	);

	vmmu_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data, .out_valid, .out_ready,
		.moved_value, .target_address, .to_register
	);

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the move unit: every opcode and access width is
// driven with bursty input and a stalling output, and each item's moved value
// and write address are checked against a local register file and memory model.
// Memory sources are steered onto bytes that were written earlier.
// ----------------------------------------------------------------------------
module tb;
	import vmmu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          N_RANDOM     = 1130;
	localparam int          SETTLE       = 100;
	localparam longint      CYCLE_LIMIT  = 600000;
	localparam logic [4:0]  OP_LAST      = 5'd19;
	localparam logic [4:0]  OP_TOP       = 5'd31;
	localparam int          MEM_BYTES    = 1 << MEM_ADDR_BITS;
	localparam logic [63:0] MEM_MASK     = 64'(MEM_BYTES - 1);

	typedef struct {
		logic [4:0]  op;
		logic [2:0]  wcode;
		logic [7:0]  dreg, didx;
		logic [5:0]  dsh;
		logic [47:0] ddisp;
		logic [7:0]  sreg, sidx;
		logic [5:0]  ssh;
		logic [63:0] sdisp;
	} move_t;

	typedef struct {
		logic [63:0] value;
		logic [47:0] addr;
		logic        to_reg;
	} move_res_t;

	typedef struct {
		logic [15:0] addr;
		int          nb;
	} store_rec_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirror of the register file and byte memory
	// ------------------------------------------------------------------------
	class move_scoreboard;
		logic [63:0] regs [REG_COUNT];
		logic [7:0]  mem  [MEM_BYTES];
		store_rec_t  stores[$];
		move_res_t   pending[$];
		int          mismatches, checked, to_mem, to_regs, dropped;

		function new();
			foreach (regs[i]) regs[i] = '0;
		endfunction

		function int size_of(logic [2:0] wc);
			case (wc)
				3'd0:    return 1;
				3'd1:    return 2;
				3'd2:    return 4;
				3'd3:    return 6;
				default: return 8;
			endcase
		endfunction

		function logic [63:0] mask_of(int nb);
			return (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 1);
		endfunction

		function logic [15:0] addr_of(logic [1:0] mode, logic [7:0] b, logic [7:0] x,
				logic [5:0] sh, logic [63:0] disp);
			logic [63:0] a;
			if (mode == DST_ABS)
				a = disp;
			else if (mode == DST_OFF)
				a = regs[b] + disp;
			else
				a = regs[b] + (regs[x] << sh) + disp;
			return a[15:0];
		endfunction

		// predict one accepted item and update state
		function void note(move_t m);
			logic [1:0]  dm;
			logic [2:0]  sm;
			logic [63:0] msk, v;
			logic [15:0] a;
			move_res_t   r;
			int          nb;
			if (m.op > OP_LAST) begin
				dropped++;
				return;
			end
			dm  = 2'(m.op / 5);
			sm  = 3'(m.op % 5);
			nb  = size_of(m.wcode);
			msk = mask_of(nb);
			v   = '0;
			case (sm)
				SRC_IMM: v = m.sdisp & msk;
				SRC_REG: v = regs[m.sreg] & msk;
				default: begin
					a = addr_of(2'(sm - 3'd1), m.sreg, m.sidx, m.ssh, m.sdisp);
					for (int i = 0; i < nb; i++)
						v[8*i +: 8] = mem[(a + i) & MEM_MASK];
				end
			endcase
			r.value = v;
			if (dm == DST_REG) begin
				regs[m.dreg] = (regs[m.dreg] & ~msk) | v;
				r.addr   = 48'(m.dreg);
				r.to_reg = 1'b1;
				to_regs++;
			end else begin
				a = addr_of(dm, m.dreg, m.didx, m.dsh, 64'(m.ddisp));
				for (int i = 0; i < nb; i++)
					mem[(a + i) & MEM_MASK] = v[8*i +: 8];
				stores.push_back('{a, nb});
				r.addr   = 48'(a);
				r.to_reg = 1'b0;
				to_mem++;
			end
			pending.push_back(r);
		endfunction

		// compare one result with the oldest expectation
		function void check(logic [63:0] v, logic [47:0] a, logic t);
			move_res_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h addr %h reg %b", v, a, t);
				return;
			end
			e = pending.pop_front();
			if (v !== e.value || a !== e.addr || t !== e.to_reg) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: exp value %h addr %h reg %b, got %h %h %b",
						checked, e.value, e.addr, e.to_reg, v, a, t);
			end
		endfunction

		// find an earlier store that covers nb bytes
		function bit pick_source(int nb, output logic [15:0] a);
			store_rec_t s;
			if (stores.size() == 0)
				return 0;
			for (int k = 0; k < 8; k++) begin
				s = stores[$urandom_range(stores.size() - 1)];
				if (s.nb >= nb) begin
					a = 16'(s.addr + $urandom_range(s.nb - nb));
					return 1;
				end
			end
			return 0;
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [4:0]  opcode;
	logic [2:0]  width_code;
	logic [7:0]  dst_reg, dst_index_reg, src_reg, src_index_reg;
	logic [5:0]  dst_shift, src_shift;
	logic [47:0] dst_disp, target_address;
	logic [63:0] src_disp, moved_value;
	logic        to_register;

	move_scoreboard sb = new();
	longint         cycles = 0;
	int             sent;

	vm_move_unit_addressing_modes i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// build one instruction; memory sources are aimed at written bytes
	function automatic move_t make_move(logic [4:0] op, logic [2:0] wc, bit extreme);
		move_t       m;
		logic [2:0]  sm;
		logic [15:0] t;
		logic [63:0] hi;
		m.op    = op;
		m.wcode = wc;
		m.dreg  = extreme ? 8'hFF : 8'($urandom);
		m.didx  = extreme ? 8'hFF : 8'($urandom);
		m.dsh   = extreme ? 6'h3F : 6'($urandom);
		m.ddisp = extreme ? '1 : 48'({$urandom, $urandom});
		m.sreg  = extreme ? 8'hFF : 8'($urandom);
		m.sidx  = extreme ? 8'hFF : 8'($urandom);
		m.ssh   = extreme ? 6'h3F : 6'($urandom);
		m.sdisp = extreme ? '1 : {$urandom, $urandom};
		if (op > OP_LAST)
			return m;
		sm = 3'(op % 5);
		if (sm >= SRC_ABS) begin
			if (!sb.pick_source(sb.size_of(wc), t)) begin
				m.op = 5'(op - sm + SRC_IMM);
				return m;
			end
			hi = {$urandom, $urandom} & ~MEM_MASK;
			case (sm)
				SRC_ABS: m.sdisp = hi | 64'(t);
				SRC_OFF: m.sdisp = hi + t - sb.regs[m.sreg];
				default: m.sdisp = hi + t - sb.regs[m.sreg] - (sb.regs[m.sidx] << m.ssh);
			endcase
		end
		return m;
	endfunction

	// drive one item and wait for it to be taken
	task automatic send(move_t m, bit hold);
		in_valid      <= 1'b1;
		opcode        <= m.op;
		width_code    <= m.wcode;
		dst_reg       <= m.dreg;
		dst_index_reg <= m.didx;
		dst_shift     <= m.dsh;
		dst_disp      <= m.ddisp;
		src_reg       <= m.sreg;
		src_index_reg <= m.sidx;
		src_shift     <= m.ssh;
		src_disp      <= m.sdisp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note(m);
		sent++;
		@(negedge clk);
		if (!hold)
			in_valid <= 1'b0;
	endtask

	// receiver: changing stall patterns plus one long hold-off
	initial begin
		int blk;
		blk       = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int pat;
			pat = $urandom_range(2);
			blk++;
			if (blk == 20) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			repeat (150) begin
				@(negedge clk);
				if (pat == 0)
					out_ready <= 1'b1;
				else if (pat == 1)
					out_ready <= 1'($urandom_range(1));
				else
					out_ready <= ($urandom_range(3) == 0);
			end
		end
	end

	// result monitor
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check(moved_value, target_address, to_register);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		int gap, burst;
		sent          = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = '0;
		width_code    = '0;
		dst_reg       = '0;
		dst_index_reg = '0;
		dst_shift     = '0;
		dst_disp      = '0;
		src_reg       = '0;
		src_index_reg = '0;
		src_shift     = '0;
		src_disp      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every opcode, extreme fields, odd widths, unknown opcodes
		send(make_move(5'd5, 3'd4, 1'b0), 1'b1);
		send(make_move(5'd10, 3'd3, 1'b0), 1'b1);
		for (int op = 0; op <= OP_LAST; op++)
			send(make_move(5'(op), 3'(op % 8), (op % 2) == 1), 1'b1);
		send(make_move(OP_TOP, 3'd7, 1'b1), 1'b1);
		send(make_move(5'(OP_LAST + 1), 3'd0, 1'b0), 1'b1);
		send(make_move(5'd0, 3'd0, 1'b0), 1'b1);

		// random bursts; memory traffic weighted up
		while (sent < N_RANDOM + 25) begin
			burst = $urandom_range(1, 20);
			gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
			for (int i = 0; i < burst; i++) begin
				logic [4:0] op;
				if ($urandom_range(15) == 0)
					op = 5'($urandom_range(OP_TOP, OP_LAST + 1));
				else if ($urandom_range(1))
					op = 5'($urandom_range(3) * 5 + $urandom_range(4, 2));
				else
					op = 5'($urandom_range(OP_LAST));
				send(make_move(op, 3'($urandom), 1'b0), (i < burst - 1) || (gap == 0));
			end
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Items sent: %0d, results checked: %0d (%0d to registers, %0d to memory)",
			sent, sb.checked, sb.to_regs, sb.to_mem);
		$display("Unknown opcodes dropped: %0d, mismatches: %0d", sb.dropped, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

[files.f]
src/vmmu_pkg.sv
src/vmmu_front.sv
src/vmmu_back.sv
src/vm_move_unit_addressing_modes.sv
tb/tb.sv
